// File: rtl/svs_pkg.sv
`default_nettype none
package svs_pkg;

  // Field and arithmetic widths.
  localparam int W         = 48;
  localparam int UW        = 47;
  localparam int FRAC_BITS = 32;
  localparam int HALF_W    = W / 2;
  localparam int PROD_W    = 2 * W;
  localparam int MID_W     = W + 2;
  localparam int MID_EXT   = PROD_W - MID_W - HALF_W;

  // Stream and configuration widths.
  localparam int IN_W   = 5 * W;
  localparam int OUT_W  = 2 * W;
  localparam int CFG_AW = 3;

  // Cycles from the input register to the result register.
  localparam int PIPE_LAT = 16;

  // Output buffer; it must hold at least every item that can be in flight.
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam logic [FIFO_AW:0] FIFO_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);

  typedef logic signed [W-1:0] sval_t;

  localparam sval_t SVAL_MAX = {1'b0, {(W-1){1'b1}}};
  localparam sval_t SVAL_MIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [UW-1:0] DT_RESET       = UW'(42949673);
  localparam logic [UW-1:0] SQRT_DT_RESET  = UW'(135818092);
  localparam logic [UW-1:0] HALF_INV_RESET = UW'(67909046);

  typedef enum logic [1:0] {
    MODE_EULER    = 2'd0,
    MODE_MILSTEIN = 2'd1,
    MODE_RK       = 2'd2
  } svs_mode_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SCHEME   = 3'd0,
    CFG_DRIFT    = 3'd1,
    CFG_VOV      = 3'd2,
    CFG_DT       = 3'd3,
    CFG_SQRT_DT  = 3'd4,
    CFG_HALF_INV = 3'd5
  } svs_cfg_e;

  typedef struct packed {
    logic [1:0]    scheme;
    sval_t         drift;
    sval_t         vov;
    logic [UW-1:0] dt;
    logic [UW-1:0] sq_dt;
    logic [UW-1:0] half_inv;
  } svs_cfg_t;

  typedef struct packed {
    sval_t price;
    sval_t vol;
    sval_t mean;
    sval_t price_shock;
    sval_t vol_shock;
  } svs_item_t;

  typedef struct packed {
    logic  ovf;
    sval_t next_vol;
    sval_t next_price;
  } svs_res_t;

  typedef struct packed {
    logic  ovf;
    sval_t val;
  } svs_sat_t;

  function automatic svs_sat_t sat_add(sval_t a, sval_t b, logic do_sub);
    logic [W:0] s;
    svs_sat_t   r;
    if (do_sub) begin
      s = {a[W-1], a} - {b[W-1], b};
    end else begin
      s = {a[W-1], a} + {b[W-1], b};
    end
    r.ovf = s[W] ^ s[W-1];
    if (r.ovf) begin
      r.val = s[W] ? SVAL_MIN : SVAL_MAX;
    end else begin
      r.val = s[W-1:0];
    end
    return r;
  endfunction

  function automatic sval_t to_sval(logic [UW-1:0] x);
    return {{(W-UW){1'b0}}, x};
  endfunction

endpackage
`default_nettype wire

// File: rtl/svs_mul.sv
`default_nettype none
// Signed fixed-point multiply, floor of the product shifted by the fraction
// width, saturated to the field range. Three register stages.
module svs_mul (
  input  logic          clk_i,
  input  svs_pkg::sval_t a_i,
  input  svs_pkg::sval_t b_i,
  output svs_pkg::sval_t p_o,
  output logic          ovf_o
);

  logic        [svs_pkg::HALF_W-1:0] a_lo, b_lo;
  logic signed [svs_pkg::HALF_W-1:0] a_hi, b_hi;

  logic        [svs_pkg::W-1:0]      ll_q;
  logic signed [svs_pkg::W-1:0]      hh_q;
  logic signed [svs_pkg::W:0]        lh_q, hl_q;

  logic        [svs_pkg::PROD_W-1:0] outer_q;
  logic signed [svs_pkg::MID_W-1:0]  mid_q;

  logic        [svs_pkg::PROD_W-1:0] full;
  logic [svs_pkg::PROD_W-svs_pkg::FRAC_BITS-svs_pkg::W:0] top;
  logic                              fits;
  svs_pkg::sval_t                    p_d;

  assign a_lo = a_i[svs_pkg::HALF_W-1:0];
  assign b_lo = b_i[svs_pkg::HALF_W-1:0];
  assign a_hi = a_i[svs_pkg::W-1:svs_pkg::HALF_W];
  assign b_hi = b_i[svs_pkg::W-1:svs_pkg::HALF_W];

  always_ff @(posedge clk_i) begin
    ll_q <= a_lo * b_lo;
    hh_q <= a_hi * b_hi;
    lh_q <= $signed({1'b0, a_lo}) * b_hi;
    hl_q <= a_hi * $signed({1'b0, b_lo});
  end

  // The high-high and low-low products do not overlap, so they simply abut.
  always_ff @(posedge clk_i) begin
    outer_q <= {hh_q, ll_q};
    mid_q   <= svs_pkg::MID_W'(lh_q) + svs_pkg::MID_W'(hl_q);
  end

  always_comb begin
    full = outer_q + {{svs_pkg::MID_EXT{mid_q[svs_pkg::MID_W-1]}}, mid_q,
                      {svs_pkg::HALF_W{1'b0}}};
    top  = full[svs_pkg::PROD_W-1:svs_pkg::FRAC_BITS+svs_pkg::W-1];
    fits = (&top) | ~(|top);
    if (fits) begin
      p_d = full[svs_pkg::FRAC_BITS+svs_pkg::W-1:svs_pkg::FRAC_BITS];
    end else begin
      p_d = full[svs_pkg::PROD_W-1] ? svs_pkg::SVAL_MIN : svs_pkg::SVAL_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    p_o   <= p_d;
    ovf_o <= ~fits;
  end

endmodule
`default_nettype wire

// File: rtl/svs_datapath.sv
`default_nettype none
module svs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  svs_pkg::svs_cfg_t  cfg_i,
  input  logic               item_valid_i,
  input  svs_pkg::svs_item_t item_i,
  output logic               res_valid_o,
  output svs_pkg::svs_res_t  res_o
);

  svs_pkg::sval_t mu, pvol, dt, sq, hh;

  assign mu   = cfg_i.drift;
  assign pvol = cfg_i.vov;
  assign dt   = svs_pkg::to_sval(cfg_i.dt);
  assign sq   = svs_pkg::to_sval(cfg_i.sq_dt);
  assign hh   = svs_pkg::to_sval(cfg_i.half_inv);

  // Delay lines; the index is the cycle at which the copy is valid.
  svs_pkg::sval_t s_dq     [1:6];
  svs_pkg::sval_t v_dq     [1:8];
  svs_pkg::sval_t ws_dq    [1:3];
  svs_pkg::sval_t wv_dq    [1:3];
  svs_pkg::sval_t vs_dq    [4:11];
  svs_pkg::sval_t pv_dq    [4:10];
  svs_pkg::sval_t ds_dq    [5:6];
  svs_pkg::sval_t dv_dq    [5:6];
  svs_pkg::sval_t hds_dq   [8:12];
  svs_pkg::sval_t hdv_dq   [8:11];
  svs_pkg::sval_t basev_dq [8:15];
  svs_pkg::sval_t bases_dq [9:15];
  svs_pkg::sval_t csm_dq   [10:15];
  svs_pkg::sval_t cvm_dq   [10:15];
  svs_pkg::sval_t predv_dq, vssq_dq, vsw_dq, cvr_dq;

  // Saturating add and subtract results.
  svs_pkg::svs_sat_t vx_q, ds_q, dv_q, predv_q, drift_q, vhat_q, basev_q;
  svs_pkg::svs_sat_t shat_q, bases_q, gv_q, gs_q;

  // Multiplier results and flags.
  svs_pkg::sval_t vs_p, ms_p, pv_p, vv_p, wsws_p, pp_p, wvwv_p, vxd_p;
  svs_pkg::sval_t msd_p, vsw_p, pvw_p, hvvs_p, hppv_p, vssq_p, pvsq_p;
  svs_pkg::sval_t hds_p, hdv_p, csm_p, cvm_p, pvhat_p, vshat_p, cvr_p, csr_p;
  logic vs_f, ms_f, pv_f, vv_f, wsws_f, pp_f, wvwv_f, vxd_f;
  logic msd_f, vsw_f, pvw_f, hvvs_f, hppv_f, vssq_f, pvsq_f;
  logic hds_f, hdv_f, csm_f, cvm_f, pvhat_f, vshat_f, cvr_f, csr_f;

  svs_pkg::sval_t hvv, hpp;

  // Overflow flags raised at each cycle, split by the scheme that uses them.
  logic [14:1] ne, nm, nr;
  logic [15:2] acc_e_q, acc_m_q, acc_r_q;
  logic [svs_pkg::PIPE_LAT:1] vld_q;

  logic              is_mil, is_rk;
  svs_pkg::sval_t    cs_sel, cv_sel;
  svs_pkg::svs_sat_t fs, fv;
  svs_pkg::svs_res_t res_d;

  // Multiplying by one half is an exact arithmetic shift.
  assign hvv = vv_p >>> 1;
  assign hpp = pp_p >>> 1;

  // Cycle 0 to 3.
  svs_mul u_vs   (.clk_i, .a_i(item_i.vol),   .b_i(item_i.price), .p_o(vs_p),   .ovf_o(vs_f));
  svs_mul u_ms   (.clk_i, .a_i(mu),           .b_i(item_i.price), .p_o(ms_p),   .ovf_o(ms_f));
  svs_mul u_pv   (.clk_i, .a_i(pvol),         .b_i(item_i.vol),   .p_o(pv_p),   .ovf_o(pv_f));
  svs_mul u_vv   (.clk_i, .a_i(item_i.vol),   .b_i(item_i.vol),   .p_o(vv_p),   .ovf_o(vv_f));
  svs_mul u_pp   (.clk_i, .a_i(pvol),         .b_i(pvol),         .p_o(pp_p),   .ovf_o(pp_f));
  svs_mul u_wsws (.clk_i, .a_i(item_i.price_shock), .b_i(item_i.price_shock),
                  .p_o(wsws_p), .ovf_o(wsws_f));
  svs_mul u_wvwv (.clk_i, .a_i(item_i.vol_shock), .b_i(item_i.vol_shock),
                  .p_o(wvwv_p), .ovf_o(wvwv_f));
  // Cycle 1 to 4.
  svs_mul u_vxd  (.clk_i, .a_i(vx_q.val),     .b_i(dt),           .p_o(vxd_p),  .ovf_o(vxd_f));
  // Cycle 3 to 6.
  svs_mul u_msd  (.clk_i, .a_i(ms_p),         .b_i(dt),           .p_o(msd_p),  .ovf_o(msd_f));
  svs_mul u_vsw  (.clk_i, .a_i(vs_p),         .b_i(ws_dq[3]),     .p_o(vsw_p),  .ovf_o(vsw_f));
  svs_mul u_pvw  (.clk_i, .a_i(pv_p),         .b_i(wv_dq[3]),     .p_o(pvw_p),  .ovf_o(pvw_f));
  svs_mul u_hvvs (.clk_i, .a_i(hvv),          .b_i(s_dq[3]),      .p_o(hvvs_p), .ovf_o(hvvs_f));
  svs_mul u_hppv (.clk_i, .a_i(hpp),          .b_i(v_dq[3]),      .p_o(hppv_p), .ovf_o(hppv_f));
  svs_mul u_vssq (.clk_i, .a_i(vs_p),         .b_i(sq),           .p_o(vssq_p), .ovf_o(vssq_f));
  svs_mul u_pvsq (.clk_i, .a_i(pv_p),         .b_i(sq),           .p_o(pvsq_p), .ovf_o(pvsq_f));
  // Cycle 4 to 7.
  svs_mul u_hds  (.clk_i, .a_i(hh),           .b_i(ds_q.val),     .p_o(hds_p),  .ovf_o(hds_f));
  svs_mul u_hdv  (.clk_i, .a_i(hh),           .b_i(dv_q.val),     .p_o(hdv_p),  .ovf_o(hdv_f));
  // Cycle 6 to 9.
  svs_mul u_csm  (.clk_i, .a_i(hvvs_p),       .b_i(ds_dq[6]),     .p_o(csm_p),  .ovf_o(csm_f));
  svs_mul u_cvm  (.clk_i, .a_i(hppv_p),       .b_i(dv_dq[6]),     .p_o(cvm_p),  .ovf_o(cvm_f));
  // Cycle 7 to 10 and 8 to 11.
  svs_mul u_pvhat(.clk_i, .a_i(pvol),         .b_i(vhat_q.val),   .p_o(pvhat_p), .ovf_o(pvhat_f));
  svs_mul u_vshat(.clk_i, .a_i(v_dq[8]),      .b_i(shat_q.val),   .p_o(vshat_p), .ovf_o(vshat_f));
  // Cycle 11 to 14 and 12 to 15.
  svs_mul u_cvr  (.clk_i, .a_i(hdv_dq[11]),   .b_i(gv_q.val),     .p_o(cvr_p),  .ovf_o(cvr_f));
  svs_mul u_csr  (.clk_i, .a_i(hds_dq[12]),   .b_i(gs_q.val),     .p_o(csr_p),  .ovf_o(csr_f));

  always_ff @(posedge clk_i) begin
    s_dq[1]  <= item_i.price;
    v_dq[1]  <= item_i.vol;
    ws_dq[1] <= item_i.price_shock;
    wv_dq[1] <= item_i.vol_shock;
    for (int k = 2; k <= 6; k++) s_dq[k] <= s_dq[k-1];
    for (int k = 2; k <= 8; k++) v_dq[k] <= v_dq[k-1];
    for (int k = 2; k <= 3; k++) begin
      ws_dq[k] <= ws_dq[k-1];
      wv_dq[k] <= wv_dq[k-1];
    end

    vs_dq[4] <= vs_p;
    for (int k = 5; k <= 11; k++) vs_dq[k] <= vs_dq[k-1];
    pv_dq[4] <= pv_p;
    for (int k = 5; k <= 10; k++) pv_dq[k] <= pv_dq[k-1];
    ds_dq[5] <= ds_q.val;
    ds_dq[6] <= ds_dq[5];
    dv_dq[5] <= dv_q.val;
    dv_dq[6] <= dv_dq[5];
    hds_dq[8] <= hds_p;
    for (int k = 9; k <= 12; k++) hds_dq[k] <= hds_dq[k-1];
    hdv_dq[8] <= hdv_p;
    for (int k = 9; k <= 11; k++) hdv_dq[k] <= hdv_dq[k-1];
    basev_dq[8] <= basev_q.val;
    for (int k = 9; k <= 15; k++) basev_dq[k] <= basev_dq[k-1];
    bases_dq[9] <= bases_q.val;
    for (int k = 10; k <= 15; k++) bases_dq[k] <= bases_dq[k-1];
    csm_dq[10] <= csm_p;
    cvm_dq[10] <= cvm_p;
    for (int k = 11; k <= 15; k++) begin
      csm_dq[k] <= csm_dq[k-1];
      cvm_dq[k] <= cvm_dq[k-1];
    end
    predv_dq <= predv_q.val;
    vssq_dq  <= vssq_p;
    vsw_dq   <= vsw_p;
    cvr_dq   <= cvr_p;

    vx_q    <= svs_pkg::sat_add(item_i.vol, item_i.mean, 1'b1);
    ds_q    <= svs_pkg::sat_add(wsws_p, dt, 1'b1);
    dv_q    <= svs_pkg::sat_add(wvwv_p, dt, 1'b1);
    predv_q <= svs_pkg::sat_add(v_dq[4], vxd_p, 1'b1);
    drift_q <= svs_pkg::sat_add(s_dq[6], msd_p, 1'b0);
    vhat_q  <= svs_pkg::sat_add(predv_dq, pvsq_p, 1'b0);
    basev_q <= svs_pkg::sat_add(predv_dq, pvw_p, 1'b0);
    shat_q  <= svs_pkg::sat_add(drift_q.val, vssq_dq, 1'b0);
    bases_q <= svs_pkg::sat_add(drift_q.val, vsw_dq, 1'b0);
    gv_q    <= svs_pkg::sat_add(pvhat_p, pv_dq[10], 1'b1);
    gs_q    <= svs_pkg::sat_add(vshat_p, vs_dq[11], 1'b1);
  end

  always_comb begin
    ne = '0;
    nm = '0;
    nr = '0;
    ne[1]  = vx_q.ovf;
    ne[3]  = vs_f | ms_f | pv_f;
    nm[3]  = vv_f | pp_f | wsws_f | wvwv_f;
    nr[3]  = wsws_f | wvwv_f;
    ne[4]  = vxd_f;
    nm[4]  = ds_q.ovf | dv_q.ovf;
    nr[4]  = ds_q.ovf | dv_q.ovf;
    ne[5]  = predv_q.ovf;
    ne[6]  = msd_f | vsw_f | pvw_f;
    nm[6]  = hvvs_f | hppv_f;
    nr[6]  = vssq_f | pvsq_f;
    ne[7]  = drift_q.ovf | basev_q.ovf;
    nr[7]  = vhat_q.ovf | hds_f | hdv_f;
    ne[8]  = bases_q.ovf;
    nr[8]  = shat_q.ovf;
    nm[9]  = csm_f | cvm_f;
    nr[10] = pvhat_f;
    nr[11] = vshat_f | gv_q.ovf;
    nr[12] = gs_q.ovf;
    nr[14] = cvr_f;
  end

  always_ff @(posedge clk_i) begin
    acc_e_q[2] <= ne[1];
    acc_m_q[2] <= nm[1];
    acc_r_q[2] <= nr[1];
    for (int t = 3; t <= 15; t++) begin
      acc_e_q[t] <= acc_e_q[t-1] | ne[t-1];
      acc_m_q[t] <= acc_m_q[t-1] | nm[t-1];
      acc_r_q[t] <= acc_r_q[t-1] | nr[t-1];
    end
  end

  // Final correction; an unused scheme code runs as Euler.
  always_comb begin
    is_mil = (cfg_i.scheme == svs_pkg::MODE_MILSTEIN);
    is_rk  = (cfg_i.scheme == svs_pkg::MODE_RK);
    cs_sel = is_mil ? csm_dq[15] : csr_p;
    cv_sel = is_mil ? cvm_dq[15] : cvr_dq;
    fs     = svs_pkg::sat_add(bases_dq[15], cs_sel, 1'b0);
    fv     = svs_pkg::sat_add(basev_dq[15], cv_sel, 1'b0);
    if (is_mil || is_rk) begin
      res_d.next_price = fs.val;
      res_d.next_vol   = fv.val;
    end else begin
      res_d.next_price = bases_dq[15];
      res_d.next_vol   = basev_dq[15];
    end
    res_d.ovf = acc_e_q[15]
              | (is_mil & (acc_m_q[15] | fs.ovf | fv.ovf))
              | (is_rk  & (acc_r_q[15] | csr_f | fs.ovf | fv.ovf));
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[svs_pkg::PIPE_LAT-1:1], item_valid_i};
    end
  end

  assign res_valid_o = vld_q[svs_pkg::PIPE_LAT];

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o == $past(item_valid_i, svs_pkg::PIPE_LAT))
    else $error("result valid does not follow the input by the pipeline latency");

endmodule
`default_nettype wire

// File: rtl/svs_ofifo.sv
`default_nettype none
// Output buffer with credit count. The count covers every accepted item not
// yet delivered, so the free-running pipeline can never overfill the buffer.
module svs_ofifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic              wr_en_i,
  input  svs_pkg::svs_res_t wr_data_i,
  input  logic              rd_ready_i,
  output logic              room_o,
  output logic              rd_valid_o,
  output svs_pkg::svs_res_t rd_data_o
);

  svs_pkg::svs_res_t          mem_q [svs_pkg::FIFO_DEPTH];
  logic [svs_pkg::FIFO_AW:0]  wr_ptr_q, rd_ptr_q, cnt_q, cnt_d, occ;
  logic                       pop;

  assign occ        = wr_ptr_q - rd_ptr_q;
  assign rd_valid_o = (wr_ptr_q != rd_ptr_q);
  assign pop        = rd_valid_o & rd_ready_i;
  assign room_o     = (cnt_q != svs_pkg::FIFO_FULL);
  assign rd_data_o  = mem_q[rd_ptr_q[svs_pkg::FIFO_AW-1:0]];

  always_comb begin
    case ({take_i, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q[svs_pkg::FIFO_AW-1:0]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= svs_pkg::FIFO_FULL)
    else $error("credit count above buffer depth");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> occ != svs_pkg::FIFO_FULL)
    else $error("result written into a full buffer");

  a_occ_in_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= cnt_q)
    else $error("buffer holds more beats than were accepted");

endmodule
`default_nettype wire

// File: rtl/stochastic_vol_sde_step_core.sv
`default_nettype none
// One stochastic-volatility path step per beat (Euler, Milstein or derivative-free
// Runge-Kutta, chosen by the scheme register) in signed Q16.32 with saturation.
// The block takes one input beat every cycle while the buffer has room; a result
// passes the input register, the datapath and the output buffer. Pipeline depth is
// set by the longest chain, the Runge-Kutta correction, which runs through 48x48
// multipliers of three stages each (four 24-bit partial products, a partial sum,
// then the final add, shift and saturation) and saturating adds. Results wait
// in a 32-beat buffer; s_axis_tready falls only when 32 accepted beats are not yet
// taken downstream. Configuration must be written only while no beat is in flight.
module stochastic_vol_sde_step_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // price, volatility, mean_level, price_shock, vol_shock
  input  logic [svs_pkg::IN_W-1:0]     s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // next_price, next_volatility
  output logic [svs_pkg::OUT_W-1:0]    m_axis_tdata,
  // overflow
  output logic                         m_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_we_i,
  input  logic [svs_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [svs_pkg::W-1:0]        cfg_data_i
);

  logic [1:0]                 scheme_q;
  svs_pkg::sval_t             drift_q, vov_q;
  logic [svs_pkg::UW-1:0]     dt_q, sq_dt_q, half_inv_q;
  svs_pkg::svs_cfg_t          cfg;

  svs_pkg::svs_item_t         item_q, item_d;
  logic                       item_vld_q;
  logic                       accept;

  logic                       res_valid;
  svs_pkg::svs_res_t          res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q   <= svs_pkg::MODE_EULER;
      drift_q    <= '0;
      vov_q      <= '0;
      dt_q       <= svs_pkg::DT_RESET;
      sq_dt_q    <= svs_pkg::SQRT_DT_RESET;
      half_inv_q <= svs_pkg::HALF_INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        svs_pkg::CFG_SCHEME:   scheme_q   <= cfg_data_i[1:0];
        svs_pkg::CFG_DRIFT:    drift_q    <= cfg_data_i;
        svs_pkg::CFG_VOV:      vov_q      <= cfg_data_i;
        svs_pkg::CFG_DT:       dt_q       <= cfg_data_i[svs_pkg::UW-1:0];
        svs_pkg::CFG_SQRT_DT:  sq_dt_q    <= cfg_data_i[svs_pkg::UW-1:0];
        svs_pkg::CFG_HALF_INV: half_inv_q <= cfg_data_i[svs_pkg::UW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.scheme   = scheme_q;
    cfg.drift    = drift_q;
    cfg.vov      = vov_q;
    cfg.dt       = dt_q;
    cfg.sq_dt    = sq_dt_q;
    cfg.half_inv = half_inv_q;
  end

  assign accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    item_d.price       = s_axis_tdata[0*svs_pkg::W +: svs_pkg::W];
    item_d.vol         = s_axis_tdata[1*svs_pkg::W +: svs_pkg::W];
    item_d.mean        = s_axis_tdata[2*svs_pkg::W +: svs_pkg::W];
    item_d.price_shock = s_axis_tdata[3*svs_pkg::W +: svs_pkg::W];
    item_d.vol_shock   = s_axis_tdata[4*svs_pkg::W +: svs_pkg::W];
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= accept;
    end
  end

  svs_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg),
    .item_valid_i (item_vld_q),
    .item_i       (item_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  svs_ofifo u_ofifo (
    .clk_i,
    .rst_ni,
    .take_i     (accept),
    .wr_en_i    (res_valid),
    .wr_data_i  (res),
    .rd_ready_i (m_axis_tready),
    .room_o     (s_axis_tready),
    .rd_valid_o (m_axis_tvalid),
    .rd_data_o  (out_res)
  );

  assign m_axis_tdata = {out_res.next_vol, out_res.next_price};
  assign m_axis_tuser = out_res.ovf;

endmodule
`default_nettype wire

// File: tb/stochastic_vol_sde_step_core_tb.sv
`timescale 1ns / 100ps
module stochastic_vol_sde_step_core_tb;
  import svs_pkg::*;

  typedef logic signed [PROD_W-1:0] wide_t;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam wide_t WIDE_MAX = (wide_t'(1) <<< (W - 1)) - wide_t'(1);
  localparam wide_t WIDE_MIN = -(wide_t'(1) <<< (W - 1));
  localparam sval_t FX_HALF = sval_t'(1) <<< (FRAC_BITS - 1);
  localparam sval_t FX_ONE = sval_t'(1) <<< FRAC_BITS;
  localparam sval_t FX_100 = sval_t'(100) <<< FRAC_BITS;
  localparam sval_t FX_0P2 = 48'sh0000_3333_3333;
  localparam sval_t FX_0P3 = 48'sh0000_4CCC_CCCD;
  localparam sval_t FX_0P05 = 48'sh0000_0CCC_CCCD;
  localparam sval_t FX_0P07 = 48'sh0000_11EB_851F;
  localparam int DIR_N = 20;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 100;

  typedef struct {
    logic [1:0] mode;
    sval_t      s, v, x, ws, wv;
    bit         typed;
    sval_t      np, nv;
    bit         ov;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]   cfg_idx_i = '0;
  logic [W-1:0]        cfg_data_i = '0;

  stochastic_vol_sde_step_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Local copy of the configuration registers, as they stand after reset.
  logic [1:0] scheme_q = MODE_EULER;
  sval_t drift_q = '0;
  sval_t vov_q = '0;
  sval_t dt_q = {1'b0, DT_RESET};
  sval_t sq_dt_q = {1'b0, SQRT_DT_RESET};
  sval_t half_inv_q = {1'b0, HALF_INV_RESET};

  bit sat_hit;
  svs_res_t pending_steps[$];
  int mismatches = 0;
  int unsigned src_idle_pct = 12;
  int unsigned snk_idle_pct = 79;

  dir_row_t dir_rows [DIR_N] = '{
    // Reset configuration, Euler: values that can be read off directly.
    '{MODE_EULER, 0, 0, 0, 0, 0, 1, 0, 0, 0},
    '{MODE_EULER, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MAX,
      1, SVAL_MAX, SVAL_MAX, 1},
    '{MODE_EULER, SVAL_MIN, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MIN,
      1, SVAL_MIN, SVAL_MAX, 1},
    '{MODE_EULER, FX_ONE, 0, 0, 0, 0, 1, FX_ONE, 0, 0},
    '{MODE_EULER, 0, SVAL_MIN, SVAL_MIN, SVAL_MIN, SVAL_MIN, 1, 0, SVAL_MIN, 0},
    '{MODE_EULER, FX_100, FX_0P2, FX_0P3, FX_0P05, -FX_0P07, 0, 0, 0, 0},
    // The reversion difference saturates and the clamped value feeds on.
    '{MODE_EULER, FX_ONE, -FX_ONE, SVAL_MAX, SVAL_MIN, SVAL_MAX, 0, 0, 0, 0},
    '{MODE_EULER, SVAL_MAX, 0, SVAL_MIN, 0, 0, 0, 0, 0, 0},
    '{MODE_MILSTEIN, FX_100, FX_0P2, FX_0P3, FX_0P05, -FX_0P07, 0, 0, 0, 0},
    '{MODE_MILSTEIN, FX_ONE, FX_ONE, 0, FX_ONE, FX_ONE, 0, 0, 0, 0},
    '{MODE_MILSTEIN, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MAX, 0, 0, 0, 0},
    '{MODE_MILSTEIN, SVAL_MIN, SVAL_MIN, SVAL_MIN, SVAL_MIN, SVAL_MIN, 0, 0, 0, 0},
    '{MODE_MILSTEIN, -FX_ONE, FX_0P2, 0, -FX_0P05, FX_0P05, 0, 0, 0, 0},
    '{MODE_RK, FX_100, FX_0P2, FX_0P3, FX_0P05, -FX_0P07, 0, 0, 0, 0},
    '{MODE_RK, FX_ONE, FX_ONE, 0, FX_ONE, -FX_ONE, 0, 0, 0, 0},
    '{MODE_RK, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MAX, 0, 0, 0, 0},
    '{MODE_RK, SVAL_MIN, SVAL_MIN, SVAL_MIN, SVAL_MIN, SVAL_MIN, 0, 0, 0, 0},
    // The unused scheme code must fall back to Euler.
    '{MODE_SPARE, FX_100, FX_0P2, FX_0P3, FX_0P05, -FX_0P07, 0, 0, 0, 0},
    '{MODE_SPARE, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MAX,
      1, SVAL_MAX, SVAL_MAX, 1},
    '{MODE_SPARE, SVAL_MIN, SVAL_MAX, SVAL_MAX, SVAL_MAX, SVAL_MIN,
      1, SVAL_MIN, SVAL_MAX, 1}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic sval_t clamp(wide_t x);
    if (x > WIDE_MAX) begin
      sat_hit = 1'b1;
      return SVAL_MAX;
    end
    if (x < WIDE_MIN) begin
      sat_hit = 1'b1;
      return SVAL_MIN;
    end
    return x[W-1:0];
  endfunction

  // Arithmetic shift of the full product rounds toward minus infinity.
  function automatic sval_t fx_mul(sval_t a, sval_t b);
    wide_t wa, wb;
    wa = a;
    wb = b;
    return clamp((wa * wb) >>> FRAC_BITS);
  endfunction

  function automatic sval_t fx_add(sval_t a, sval_t b);
    wide_t wa, wb;
    wa = a;
    wb = b;
    return clamp(wa + wb);
  endfunction

  function automatic sval_t fx_sub(sval_t a, sval_t b);
    wide_t wa, wb;
    wa = a;
    wb = b;
    return clamp(wa - wb);
  endfunction

  function automatic svs_res_t predict_path_step(svs_item_t it);
    sval_t s, v, x, ws, wv, vs, drift_s, base_s, pv, pred_v, base_v;
    sval_t shat, vhat, gs, gv, cs, cv;
    svs_res_t r;
    s = it.price;
    v = it.vol;
    x = it.mean;
    ws = it.price_shock;
    wv = it.vol_shock;
    sat_hit = 1'b0;

    vs = fx_mul(v, s);
    drift_s = fx_add(s, fx_mul(fx_mul(drift_q, s), dt_q));
    base_s = fx_add(drift_s, fx_mul(vs, ws));
    pv = fx_mul(vov_q, v);
    pred_v = fx_sub(v, fx_mul(fx_sub(v, x), dt_q));
    base_v = fx_add(pred_v, fx_mul(pv, wv));

    r.next_price = base_s;
    r.next_vol = base_v;
    if (scheme_q == MODE_MILSTEIN) begin
      cs = fx_mul(fx_mul(fx_mul(FX_HALF, fx_mul(v, v)), s), fx_sub(fx_mul(ws, ws), dt_q));
      cv = fx_mul(fx_mul(fx_mul(FX_HALF, fx_mul(vov_q, vov_q)), v),
                  fx_sub(fx_mul(wv, wv), dt_q));
      r.next_price = fx_add(base_s, cs);
      r.next_vol = fx_add(base_v, cv);
    end else if (scheme_q == MODE_RK) begin
      shat = fx_add(drift_s, fx_mul(vs, sq_dt_q));
      vhat = fx_add(pred_v, fx_mul(pv, sq_dt_q));
      gs = fx_sub(fx_mul(v, shat), vs);
      gv = fx_sub(fx_mul(vov_q, vhat), pv);
      cs = fx_mul(fx_mul(half_inv_q, fx_sub(fx_mul(ws, ws), dt_q)), gs);
      cv = fx_mul(fx_mul(half_inv_q, fx_sub(fx_mul(wv, wv), dt_q)), gv);
      r.next_price = fx_add(base_s, cs);
      r.next_vol = fx_add(base_v, cv);
    end
    r.ovf = sat_hit;
    return r;
  endfunction

  // Mostly values of a given magnitude, with the extremes and full-width noise mixed in.
  function automatic sval_t pick_val(int unsigned bits);
    logic [63:0] raw;
    sval_t m;
    raw = {$urandom, $urandom};
    case ($urandom_range(15))
      0: return SVAL_MAX;
      1: return SVAL_MIN;
      2: return '0;
      3, 4: return raw[W-1:0];
      default: begin
        m = raw[W-1:0] & ((48'd1 << bits) - 48'd1);
        return raw[63] ? -m : m;
      end
    endcase
  endfunction

  function automatic logic [UW-1:0] pick_mag(int unsigned bits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(9) == 0) return raw[UW-1:0];
    return raw[UW-1:0] & ((47'd1 << bits) - 47'd1);
  endfunction

  task automatic cfg_write(svs_cfg_e idx, logic [W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_config(logic [1:0] mode, sval_t drift, sval_t vov,
                              logic [UW-1:0] dt, logic [UW-1:0] sq, logic [UW-1:0] hinv);
    cfg_write(CFG_SCHEME, {{(W-2){1'b0}}, mode});
    cfg_write(CFG_DRIFT, drift);
    cfg_write(CFG_VOV, vov);
    cfg_write(CFG_DT, {1'b0, dt});
    cfg_write(CFG_SQRT_DT, {1'b0, sq});
    cfg_write(CFG_HALF_INV, {1'b0, hinv});
    cfg_we_i <= 1'b0;
    scheme_q = mode;
    drift_q = drift;
    vov_q = vov;
    dt_q = {1'b0, dt};
    sq_dt_q = {1'b0, sq};
    half_inv_q = {1'b0, hinv};
  endtask

  // tvalid is only lowered on an idle cycle, so back-to-back beats keep it high.
  task automatic send_step(svs_item_t it, bit typed, svs_res_t typed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= {it.vol_shock, it.price_shock, it.mean, it.vol, it.price};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_steps.push_back(typed ? typed_res : predict_path_step(it));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    svs_res_t want;
    sval_t got_price, got_vol;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_price = m_axis_tdata[W-1:0];
      got_vol = m_axis_tdata[OUT_W-1:W];
      if (pending_steps.size() == 0) begin
        $error("result beat with no step outstanding: price %h vol %h", got_price, got_vol);
        mismatches++;
      end else begin
        want = pending_steps.pop_front();
        if (got_price !== want.next_price) begin
          $error("next_price: expected %h, got %h", want.next_price, got_price);
          mismatches++;
        end
        if (got_vol !== want.next_vol) begin
          $error("next_volatility: expected %h, got %h", want.next_vol, got_vol);
          mismatches++;
        end
        if (m_axis_tuser !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    svs_item_t it;
    svs_res_t typed_res;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != scheme_q) begin
        drain();
        apply_config(dir_rows[i].mode, drift_q, vov_q, dt_q[UW-1:0], sq_dt_q[UW-1:0],
                     half_inv_q[UW-1:0]);
      end
      it.price = dir_rows[i].s;
      it.vol = dir_rows[i].v;
      it.mean = dir_rows[i].x;
      it.price_shock = dir_rows[i].ws;
      it.vol_shock = dir_rows[i].wv;
      typed_res.next_price = dir_rows[i].np;
      typed_res.next_vol = dir_rows[i].nv;
      typed_res.ovf = dir_rows[i].ov;
      send_step(it, dir_rows[i].typed, typed_res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_pct = (ph < 3) ? 12 : (ph < 6) ? 79 : 0;
      snk_idle_pct = (ph < 3) ? 79 : (ph < 6) ? 12 : 0;
      drain();
      case (ph)
        2: apply_config(ph % 4, SVAL_MAX, SVAL_MIN, '1, '0, '1);
        5: apply_config(ph % 4, SVAL_MIN, SVAL_MAX, '0, '1, '0);
        default: apply_config(ph % 4, pick_val(31), pick_val(33), pick_mag(26),
                              pick_mag(30), pick_mag(35));
      endcase
      repeat (PHASE_BEATS) begin
        it.price = pick_val(40);
        it.vol = pick_val(32);
        it.mean = pick_val(32);
        it.price_shock = pick_val(31);
        it.vol_shock = pick_val(31);
        send_step(it, 1'b0, '0);
      end
    end

    drain();
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("** stochastic_vol_sde_step_core: PASSED **");
    end else begin
      $display("** stochastic_vol_sde_step_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** stochastic_vol_sde_step_core: FAILED **");
    $finish;
  end

endmodule
